// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define RRS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define RRS_ASSERT_NEVER(name, clk, rst_n, cond) \
  `RRS_ASSERT(name, clk, rst_n, !(cond))

`endif

// File: hw/rtl/rrs_pkg.sv
// Shared constants and types of the round robin task scheduler.
package rrs_pkg;

  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [31:0] MIN_STACK_BYTES = 32'd20;

  // Broadcast control from the sequencer to every slot cell.
  typedef struct packed {
    logic             create;
    logic             delay;
    logic             tick;
    logic             save;
    logic             scan_load;
    logic             scan_run;
    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] first_idx;
    logic [31:0]      sp;
    logic [31:0]      ticks;
  } cell_ctl_t;

endpackage

// File: hw/rtl/rrs_cell.sv
// One task slot: state, sleep count, saved stack pointer and scan token.
module rrs_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [rrs_pkg::IDX_W-1:0] cell_idx_i,
  input  logic                    used_i,
  input  rrs_pkg::cell_ctl_t      ctl_i,
  input  logic                    tok_i,
  output logic                    tok_o,
  output logic                    hit_o,
  output logic [31:0]             sp_o
);

  localparam logic [1:0] SLOT_READY   = 2'd0;
  localparam logic [1:0] SLOT_RUNNING = 2'd1;
  localparam logic [1:0] SLOT_SLEEP   = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] sleep_q, sleep_d;
  logic [31:0] sp_q, sp_d;
  logic        tok_q, tok_d;
  logic        sel;

  // Only an occupied slot may claim the token
  assign sel   = (cell_idx_i == ctl_i.sel_idx);
  assign hit_o = ctl_i.scan_run & tok_q & used_i & (state_q == SLOT_READY);
  assign tok_o = tok_q;
  assign sp_o  = sp_q;

  // Load the token at the first candidate, then pass it on while scanning
  always_comb begin
    if (ctl_i.scan_load) begin
      tok_d = (cell_idx_i == ctl_i.first_idx);
    end else if (ctl_i.scan_run) begin
      tok_d = tok_i;
    end else begin
      tok_d = 1'b0;
    end
  end

  // Update the slot on addressed ops, ticks while asleep and token claims
  always_comb begin
    state_d = state_q;
    sleep_d = sleep_q;
    sp_d    = sp_q;
    if (ctl_i.create && sel) begin
      state_d = SLOT_READY;
      sleep_d = 32'd0;
      sp_d    = ctl_i.sp;
    end
    if (ctl_i.delay && sel) begin
      state_d = SLOT_SLEEP;
      sleep_d = ctl_i.ticks;
    end
    if (ctl_i.tick && used_i && (state_q == SLOT_SLEEP)) begin
      if (sleep_q <= 32'd1) begin
        sleep_d = 32'd0;
        state_d = SLOT_READY;
      end else begin
        sleep_d = sleep_q - 32'd1;
      end
    end
    if (ctl_i.save && sel) begin
      sp_d = ctl_i.sp;
      if (state_q == SLOT_RUNNING) begin
        state_d = SLOT_READY;
      end
    end
    if (hit_o) begin
      state_d = SLOT_RUNNING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Slot contents are defined once the slot is created
  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    sleep_q <= sleep_d;
    sp_q    <= sp_d;
  end

endmodule

// File: hw/rtl/rrs_ctrl.sv
// Scheduler sequencer: opcode decode, scan control, mode and result registers.
`include "assert_macros.svh"

module rrs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [31:0]               new_task_sp_i,
  input  logic [31:0]               stack_bytes_i,
  input  logic [31:0]               delay_ticks_i,
  input  logic [31:0]               current_sp_i,
  input  logic                      cfg_we_i,
  input  logic [31:0]               cfg_wdata_i,
  input  logic                      hit_any_i,
  input  logic [31:0]               hit_sp_i,
  output logic [rrs_pkg::CNT_W-1:0] slots_used_o,
  output rrs_pkg::cell_ctl_t        ctl_o,
  output logic                      done_o,
  output logic                      status_o,
  output logic [31:0]               next_sp_o,
  output logic                      switch_request_o,
  output logic [3:0]                active_slot_o,
  output logic                      idle_active_o
);

  localparam int unsigned IW = rrs_pkg::IDX_W;
  localparam int unsigned CW = rrs_pkg::CNT_W;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELAY  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_SWITCH = 2'd3;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_TASK = 2'd1;
  localparam logic [1:0] MODE_IDLE = 2'd2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] used_q, used_d;
  logic [IW-1:0] run_q, run_d;
  logic [1:0]    mode_q, mode_d;
  logic [31:0]   idle_sp_q, idle_sp_d;
  logic [IW-1:0] scan_idx_q, scan_idx_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          status_q, status_d;
  logic [31:0]   next_q, next_d;
  logic          req_q, req_d;

  logic          accept;
  logic          run_valid;
  logic          create_bad;
  logic [CW-1:0] start_pos;
  logic [CW-1:0] base_pos;
  logic [CW-1:0] base_inc;
  logic [IW-1:0] first_idx;
  logic [CW-1:0] scan_inc;
  logic          scan_last;

  assign busy_o           = (state_q == ST_SCAN);
  assign accept           = start_i && !busy_o;
  assign slots_used_o     = used_q;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign next_sp_o        = next_q;
  assign switch_request_o = req_q;
  assign active_slot_o    = 4'(run_q);
  assign idle_active_o    = (mode_q == MODE_IDLE);

  assign run_valid  = (CW'(run_q) < used_q);
  assign create_bad = (used_q >= CW'(rrs_pkg::MAX_TASKS)) ||
                      (stack_bytes_i < rrs_pkg::MIN_STACK_BYTES) ||
                      (stack_bytes_i[1:0] != 2'b00);

  // Find the first candidate slot after the search start, circularly
  always_comb begin
    if (mode_q == MODE_INIT) begin
      start_pos = (used_q == '0) ? '0 : used_q - CW'(1);
    end else begin
      start_pos = CW'(run_q);
    end
    if ((used_q == '0) || (start_pos >= used_q)) begin
      base_pos = (used_q == '0) ? '0 : used_q - CW'(1);
    end else begin
      base_pos = start_pos;
    end
    base_inc  = base_pos + CW'(1);
    first_idx = (base_inc >= used_q) ? '0 : base_inc[IW-1:0];
  end

  assign scan_inc  = CW'(scan_idx_q) + CW'(1);
  assign scan_last = (used_q == '0) || ((CW'(cnt_q) + CW'(1)) >= used_q);

  // Decode the accepted opcode and step the scan
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    run_d      = run_q;
    mode_d     = mode_q;
    idle_sp_d  = idle_sp_q;
    scan_idx_d = scan_idx_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    status_d   = status_q;
    next_d     = next_q;
    req_d      = req_q;
    ctl_o      = '0;
    ctl_o.first_idx = first_idx;
    ctl_o.ticks     = delay_ticks_i;

    if (cfg_we_i && (mode_q == MODE_INIT)) begin
      idle_sp_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = 1'b0;
          next_d   = 32'd0;
          req_d    = 1'b0;
          case (opcode_i)
            OP_CREATE: begin
              done_d = 1'b1;
              if (create_bad) begin
                status_d = 1'b1;
              end else begin
                ctl_o.create  = 1'b1;
                ctl_o.sel_idx = used_q[IW-1:0];
                ctl_o.sp      = new_task_sp_i;
                used_d        = used_q + CW'(1);
              end
            end
            OP_DELAY: begin
              done_d        = 1'b1;
              ctl_o.sel_idx = run_q;
              if ((delay_ticks_i != 32'd0) && (mode_q == MODE_TASK) && run_valid) begin
                ctl_o.delay = 1'b1;
                req_d       = 1'b1;
              end
            end
            OP_TICK: begin
              done_d     = 1'b1;
              ctl_o.tick = 1'b1;
              req_d      = 1'b1;
            end
            OP_SWITCH: begin
              ctl_o.sel_idx   = run_q;
              ctl_o.sp        = current_sp_i;
              ctl_o.scan_load = 1'b1;
              if ((mode_q == MODE_TASK) && run_valid) begin
                ctl_o.save = 1'b1;
              end
              if (mode_q == MODE_IDLE) begin
                idle_sp_d = current_sp_i;
              end
              scan_idx_d = first_idx;
              cnt_d      = '0;
              state_d    = ST_SCAN;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl_o.scan_run = 1'b1;
        if (hit_any_i) begin
          run_d   = scan_idx_q;
          mode_d  = MODE_TASK;
          next_d  = hit_sp_i;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (scan_last) begin
          mode_d  = MODE_IDLE;
          next_d  = idle_sp_q;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d      = cnt_q + IW'(1);
          scan_idx_d = (scan_inc >= used_q) ? '0 : scan_inc[IW-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      run_q     <= '0;
      mode_q    <= MODE_INIT;
      idle_sp_q <= 32'd0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      run_q     <= run_d;
      mode_q    <= mode_d;
      idle_sp_q <= idle_sp_d;
      done_q    <= done_d;
    end
  end

  // Scan position and result payload
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    cnt_q      <= cnt_d;
    status_q   <= status_d;
    next_q     <= next_d;
    req_q      <= req_d;
  end

  `RRS_ASSERT(a_task_slot_in_range, clk_i, rst_ni, (mode_q == MODE_TASK) |-> run_valid)
  `RRS_ASSERT(a_used_stable_in_scan, clk_i, rst_ni, (state_q == ST_SCAN) |=> $stable(used_q))
  `RRS_ASSERT(a_scan_count_bounded, clk_i, rst_ni, ((state_q == ST_SCAN) && (used_q != '0)) |-> (CW'(cnt_q) < used_q))

endmodule

// File: hw/rtl/round_robin_task_scheduler.sv
// Top level of the round robin task scheduler: register port, slot chain, sequencer.
//
// Usage: pulse start_i with opcode_i and the operand ports while busy_o is low;
// the item is transferred at that edge. Opcodes: create a slot, delay the running
// task, tick the sleepers, switch context. The result (status_o, next_sp_o,
// switch_request_o, active_slot_o, idle_active_o) is valid for exactly one cycle
// while done_o is high; the receiver has no way to hold it off.
// For create, delay and tick, done_o rises the cycle after the transfer, and a
// new item may be started in that same cycle.
// Switch saves the current stack pointer (not on the first switch after reset),
// then a scan token walks the chain of slot cells one cell per cycle; it stops at
// the first ready slot, or selects the idle context once every occupied slot has
// been passed. busy_o stays high during the scan.
// idle_initial_sp sits at byte address 0 of the APB port; write it only while the
// block is idle. Before the first switch a write also seeds the idle context.
// Reset empties the slot table, selects slot 0 and puts the scheduler in its
// start-up mode with the idle stack pointer at zero; no clearing pass is needed.
`include "assert_macros.svh"

module round_robin_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] new_task_sp_i,
  input  logic [31:0] stack_bytes_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] current_sp_i,
  output logic        done_o,
  output logic        status_o,
  output logic [31:0] next_sp_o,
  output logic        switch_request_o,
  output logic [3:0]  active_slot_o,
  output logic        idle_active_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N  = rrs_pkg::MAX_TASKS;
  localparam int unsigned IW = rrs_pkg::IDX_W;
  localparam int unsigned CW = rrs_pkg::CNT_W;
  localparam logic REG_IDLE_SP = 1'b0;

  logic [31:0]        idle_init_q, idle_init_d;
  logic               cfg_we;
  logic [CW-1:0]      slots_used;
  rrs_pkg::cell_ctl_t ctl;
  logic [N-1:0]       tok_out;
  logic [N-1:0]       tok_in;
  logic [N-1:0]       hit;
  logic [N-1:0]       used;
  logic [N-1:0]       last;
  logic [31:0]        sp [N];
  logic [31:0]        hit_sp;

  // Register port: writes complete in the access cycle
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_SP);
  assign prdata = (paddr[2] == REG_IDLE_SP) ? idle_init_q : 32'd0;
  assign idle_init_d = cfg_we ? pwdata : idle_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_init_q <= 32'd0;
    end else begin
      idle_init_q <= idle_init_d;
    end
  end

  // Route the token around the occupied part of the chain
  always_comb begin
    for (int i = 0; i < N; i++) begin
      used[i] = (CW'(i) < slots_used);
      last[i] = ((CW'(i) + CW'(1)) == slots_used);
    end
    tok_in[0] = |(tok_out & last);
    for (int i = 1; i < N; i++) begin
      tok_in[i] = tok_out[i-1] & !last[i-1];
    end
  end

  // Select the stack pointer of the claiming cell
  always_comb begin
    hit_sp = 32'd0;
    for (int i = 0; i < N; i++) begin
      hit_sp = hit_sp | (sp[i] & {32{hit[i]}});
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    rrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IW'(g)),
      .used_i     (used[g]),
      .ctl_i      (ctl),
      .tok_i      (tok_in[g]),
      .tok_o      (tok_out[g]),
      .hit_o      (hit[g]),
      .sp_o       (sp[g])
    );
  end

  rrs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .new_task_sp_i    (new_task_sp_i),
    .stack_bytes_i    (stack_bytes_i),
    .delay_ticks_i    (delay_ticks_i),
    .current_sp_i     (current_sp_i),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata),
    .hit_any_i        (|hit),
    .hit_sp_i         (hit_sp),
    .slots_used_o     (slots_used),
    .ctl_o            (ctl),
    .done_o           (done_o),
    .status_o         (status_o),
    .next_sp_o        (next_sp_o),
    .switch_request_o (switch_request_o),
    .active_slot_o    (active_slot_o),
    .idle_active_o    (idle_active_o)
  );

  `RRS_ASSERT(a_single_token, clk_i, rst_ni, $onehot0(tok_out))
  `RRS_ASSERT(a_hit_only_in_scan, clk_i, rst_ni, (|hit) |-> busy_o)

endmodule

// File: dv/sched_tb_pkg.sv
// Opcode, state and result definitions shared by the scheduler testbench files.
`timescale 1ns / 100ps

package sched_tb_pkg;

  // Operation codes carried on opcode_i.
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELAY  = 2'd1,
    OP_TICK   = 2'd2,
    OP_SWITCH = 2'd3
  } sched_op_e;

  // Per-slot task state.
  typedef enum logic [1:0] {
    SLOT_READY    = 2'd0,
    SLOT_RUNNING  = 2'd1,
    SLOT_SLEEPING = 2'd2
  } slot_state_e;

  // What the scheduler is running.
  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_TASK = 2'd1,
    MODE_IDLE = 2'd2
  } sched_mode_e;

  localparam logic       STATUS_OK       = 1'b0;
  localparam logic       STATUS_REJECTED = 1'b1;
  localparam logic [2:0] IDLE_SP_ADDR    = 3'd0;

  // One result transfer as seen on the output ports.
  typedef struct packed {
    logic        status;
    logic [31:0] next_sp;
    logic        switch_req;
    logic [3:0]  active_slot;
    logic        idle_active;
  } sched_result_t;

endpackage

// File: dv/sched_checker.sv
// Scheduler checker: tracks task table state, predicts each result and compares.
`timescale 1ns / 100ps

module sched_checker
  import rrs_pkg::*;
  import sched_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] new_task_sp_i,
  input  logic [31:0] stack_bytes_i,
  input  logic [31:0] delay_ticks_i,
  input  logic [31:0] current_sp_i,
  input  logic        done_o,
  input  logic        status_o,
  input  logic [31:0] next_sp_o,
  input  logic        switch_request_o,
  input  logic [3:0]  active_slot_o,
  input  logic        idle_active_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatch_count_o,
  output int unsigned results_owed_o
);

  localparam int unsigned MAX_REPORTS = 40;

  // Shadow of the task table and scheduler state
  slot_state_e   slot_st   [MAX_TASKS];
  logic [31:0]   sleep_cnt [MAX_TASKS];
  logic [31:0]   resume_sp [MAX_TASKS];
  int unsigned   n_slots;
  int unsigned   run_slot;
  sched_mode_e   mode;
  logic [31:0]   idle_sp;
  logic [31:0]   idle_sp_reg;
  sched_result_t sched_outcome_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count_o < MAX_REPORTS) begin
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    end
    mismatch_count_o++;
  endtask

  // Hand the CPU to the first ready slot after 'from', circularly; idle if none.
  function automatic logic [31:0] pick_ready_slot(input int unsigned from);
    int unsigned idx;
    int unsigned k;
    logic        found;
    logic [31:0] sp;
    idx = from;
    found = 1'b0;
    sp = idle_sp;
    if (n_slots == 0 || from >= n_slots) begin
      idx = (n_slots == 0) ? 0 : n_slots - 1;
    end
    for (k = 0; k < n_slots; k++) begin
      if (!found) begin
        idx++;
        if (idx >= n_slots) begin
          idx = 0;
        end
        if (slot_st[idx] == SLOT_READY) begin
          slot_st[idx] = SLOT_RUNNING;
          run_slot = idx;
          found = 1'b1;
          sp = resume_sp[idx];
        end
      end
    end
    mode = found ? MODE_TASK : MODE_IDLE;
    return sp;
  endfunction

  // Advance the shadow state by one command and return the result it yields.
  function automatic sched_result_t predict_sched_step(
      input sched_op_e op, input logic [31:0] new_sp, input logic [31:0] bytes,
      input logic [31:0] ticks, input logic [31:0] cur_sp);
    sched_result_t res;
    int unsigned   i;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_CREATE: begin
        if (n_slots >= MAX_TASKS || bytes < MIN_STACK_BYTES || bytes[1:0] != 2'b00) begin
          res.status = STATUS_REJECTED;
        end else begin
          slot_st[n_slots] = SLOT_READY;
          sleep_cnt[n_slots] = '0;
          resume_sp[n_slots] = new_sp;
          n_slots++;
        end
      end
      OP_DELAY: begin
        if (ticks != 0 && mode == MODE_TASK && run_slot < n_slots) begin
          slot_st[run_slot] = SLOT_SLEEPING;
          sleep_cnt[run_slot] = ticks;
          res.switch_req = 1'b1;
        end
      end
      OP_TICK: begin
        for (i = 0; i < n_slots; i++) begin
          if (slot_st[i] == SLOT_SLEEPING) begin
            if (sleep_cnt[i] <= 1) begin
              sleep_cnt[i] = '0;
              slot_st[i] = SLOT_READY;
            end else begin
              sleep_cnt[i] = sleep_cnt[i] - 1;
            end
          end
        end
        res.switch_req = 1'b1;
      end
      default: begin
        if (mode == MODE_TASK) begin
          if (run_slot < n_slots) begin
            resume_sp[run_slot] = cur_sp;
            if (slot_st[run_slot] == SLOT_RUNNING) begin
              slot_st[run_slot] = SLOT_READY;
            end
          end
          res.next_sp = pick_ready_slot(run_slot);
        end else if (mode == MODE_IDLE) begin
          idle_sp = cur_sp;
          res.next_sp = pick_ready_slot(run_slot);
        end else begin
          // first switch after reset: start at the lowest ready slot
          res.next_sp = pick_ready_slot((n_slots == 0) ? 0 : n_slots - 1);
        end
      end
    endcase
    res.active_slot = run_slot[3:0];
    res.idle_active = (mode == MODE_IDLE);
    return res;
  endfunction

  // Compare results, track register traffic, then predict new commands
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_st[i] = SLOT_READY;
        sleep_cnt[i] = '0;
        resume_sp[i] = '0;
      end
      n_slots = 0;
      run_slot = 0;
      mode = MODE_INIT;
      idle_sp_reg = '0;
      idle_sp = '0;
      sched_outcome_q.delete();
      mismatch_count_o = 0;
      results_owed_o = 0;
    end else begin
      if (done_o) begin
        if (sched_outcome_q.size() == 0) begin
          report_mismatch("unexpected result, next_sp", next_sp_o, '0);
        end else begin
          want = sched_outcome_q.pop_front();
          if (status_o !== want.status) begin
            report_mismatch("status", status_o, want.status);
          end
          if (next_sp_o !== want.next_sp) begin
            report_mismatch("next_sp", next_sp_o, want.next_sp);
          end
          if (switch_request_o !== want.switch_req) begin
            report_mismatch("switch_request", switch_request_o, want.switch_req);
          end
          if (active_slot_o !== want.active_slot) begin
            report_mismatch("active_slot", active_slot_o, want.active_slot);
          end
          if (idle_active_o !== want.idle_active) begin
            report_mismatch("idle_active", idle_active_o, want.idle_active);
          end
        end
      end
      if (psel && penable && pready && paddr == IDLE_SP_ADDR) begin
        if (pwrite) begin
          idle_sp_reg = pwdata;
          if (mode == MODE_INIT) begin
            idle_sp = pwdata;
          end
        end else if (prdata !== idle_sp_reg) begin
          report_mismatch("idle_initial_sp readback", prdata, idle_sp_reg);
        end
      end
      if (start_i && !busy_o) begin
        sched_outcome_q.push_back(predict_sched_step(sched_op_e'(opcode_i), new_task_sp_i,
                                                     stack_bytes_i, delay_ticks_i,
                                                     current_sp_i));
      end
      results_owed_o = sched_outcome_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Testbench top: clock, reset, command and register stimulus, and the verdict.
`timescale 1ns / 100ps

module testbench;
  import sched_tb_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned STALL_LIMIT     = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [31:0] new_task_sp_i;
  logic [31:0] stack_bytes_i;
  logic [31:0] delay_ticks_i;
  logic [31:0] current_sp_i;
  logic        done_o;
  logic        status_o;
  logic [31:0] next_sp_o;
  logic        switch_request_o;
  logic [3:0]  active_slot_o;
  logic        idle_active_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;
  logic [31:0] rd_data;

  // Sender idle percentage per phase
  int unsigned idle_pct[NUM_PHASES] = '{0, 48, 0, 29};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  round_robin_task_scheduler dut (.*);

  sched_checker u_checker (
    .*,
    .mismatch_count_o (mismatch_count),
    .results_owed_o   (results_owed)
  );

  // Abort when nothing transfers for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Issue one command; called and returns at a falling edge
  task automatic send_cmd(input sched_op_e op, input logic [31:0] new_sp,
                          input logic [31:0] bytes, input logic [31:0] ticks,
                          input logic [31:0] cur_sp);
    start_i = 1'b1;
    opcode_i = op;
    new_task_sp_i = new_sp;
    stack_bytes_i = bytes;
    delay_ticks_i = ticks;
    current_sp_i = cur_sp;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write the idle stack pointer register and read it back
  task automatic set_idle_sp(input logic [31:0] value);
    apb_access(1'b1, IDLE_SP_ADDR, value, rd_data);
    apb_access(1'b0, IDLE_SP_ADDR, '0, rd_data);
  endtask

  // Drop start and wait until every result has come back
  task automatic drain;
    start_i = 1'b0;
    while (results_owed != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic directed_cmds;
    // before any switch: delay ignored, tick with no tasks, invalid creates
    send_cmd(OP_DELAY,  '0, '0, 32'd5, '0);
    send_cmd(OP_TICK,   '0, '0, '0, '0);
    send_cmd(OP_CREATE, 32'h1000, 32'd16, '0, '0);
    send_cmd(OP_CREATE, 32'h1000, 32'd22, '0, '0);
    send_cmd(OP_CREATE, 32'h1000, 32'd0, '0, '0);
    send_cmd(OP_CREATE, 32'h1000, 32'hFFFF_FFFF, '0, '0);
    // first switch with an empty table starts the idle context
    send_cmd(OP_SWITCH, '0, '0, '0, 32'h1234_5678);
    send_cmd(OP_DELAY,  '0, '0, 32'd3, '0);
    // smallest and largest legal stacks
    send_cmd(OP_CREATE, 32'h0000_0000, 32'd20, '0, '0);
    send_cmd(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFC, '0, '0);
    send_cmd(OP_SWITCH, '0, '0, '0, 32'h0000_0000);
    send_cmd(OP_DELAY,  '0, '0, 32'd0, '0);
    send_cmd(OP_DELAY,  '0, '0, 32'd1, '0);
    // sleeping task stays asleep across the switch
    send_cmd(OP_SWITCH, '0, '0, '0, 32'hFFFF_FFFF);
    send_cmd(OP_DELAY,  '0, '0, 32'hFFFF_FFFF, '0);
    // nothing ready: fall back to idle
    send_cmd(OP_SWITCH, '0, '0, '0, 32'hA5A5_5A5A);
    send_cmd(OP_TICK,   '0, '0, '0, '0);
    send_cmd(OP_SWITCH, '0, '0, '0, 32'h0F0F_F0F0);
    // the lone ready task is picked again
    send_cmd(OP_SWITCH, '0, '0, '0, 32'h5555_AAAA);
    send_cmd(OP_TICK,   '0, '0, '0, '0);
    send_cmd(OP_SWITCH, '0, '0, '0, 32'hDEAD_BEEF);
  endtask

  task automatic random_cmds(input int unsigned pct);
    sched_op_e   op;
    logic [31:0] bytes;
    logic [31:0] ticks;
    int unsigned pick;
    for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        op = OP_CREATE;
      end else if (pick < 32) begin
        op = OP_DELAY;
      end else if (pick < 58) begin
        op = OP_TICK;
      end else begin
        op = OP_SWITCH;
      end
      // mostly legal stack sizes, some near the minimum, some arbitrary
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        bytes = 32'd20 + 32'd4 * $urandom_range(0, 2000);
      end else if (pick < 85) begin
        bytes = $urandom;
      end else begin
        bytes = $urandom_range(0, 23);
      end
      // mostly short sleeps so tasks come back
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        ticks = '0;
      end else if (pick < 11) begin
        ticks = $urandom;
      end else if (pick < 85) begin
        ticks = $urandom_range(1, 4);
      end else begin
        ticks = $urandom_range(5, 40);
      end
      send_cmd(op, $urandom, bytes, ticks, $urandom);
      // hold off between transfers
      if (pct != 0 && $urandom_range(1, 100) <= pct) begin
        start_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = OP_CREATE;
    new_task_sp_i = '0;
    stack_bytes_i = '0;
    delay_ticks_i = '0;
    current_sp_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = IDLE_SP_ADDR;
    pwdata = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_idle_sp(32'hFFFF_FFFF);
    directed_cmds();
    drain();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_idle_sp(32'h0000_0000);
        1: set_idle_sp($urandom);
        2: set_idle_sp(32'hFFFF_FFFF);
        default: set_idle_sp($urandom);
      endcase
      random_cmds(idle_pct[ph]);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_cell.sv
hw/rtl/rrs_ctrl.sv
hw/rtl/round_robin_task_scheduler.sv
dv/sched_tb_pkg.sv
dv/sched_checker.sv
dv/testbench.sv
